// ===== rtl/quaternion_slerp_macros.svh =====
// ----------------------------------------------------------------------------
// Quaternion slerp assertion macros
// Shared property wrappers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_SLERP_MACROS_SVH
`define QUATERNION_SLERP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define QS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("quaternion_slerp: invariant violated");
`define QS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quaternion_slerp: sequence violated");
`else
`define QS_ASSERT_ALWAYS(lbl, cond)
`define QS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/qslerp_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion slerp package
// Widths, constants, CORDIC angle table and the item and cell types.
// ----------------------------------------------------------------------------
package qslerp_pkg;

    localparam int COMP_W       = 16;
    localparam int WEIGHT_W     = 16;
    localparam int THR_W        = 29;
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 29;
    localparam int SQRT_W       = 58;
    localparam int DIV_STEPS    = 32;
    localparam int DIV_W        = 61;
    localparam int CRD_W        = 36;

    localparam logic [THR_W-1:0]        THR_RESET   = 29'd268435188;
    localparam logic [WEIGHT_W-1:0]     WEIGHT_ONE  = 16'd32768;
    localparam logic signed [CRD_W-1:0] CORDIC_KINV = 36'sd652032874;

    // atan(2^-i) in Q.30 radians
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef logic signed [COMP_W-1:0] comp_t;

    typedef struct packed {
        comp_t               a_x;
        comp_t               a_y;
        comp_t               a_z;
        comp_t               a_w;
        comp_t               b_x;
        comp_t               b_y;
        comp_t               b_z;
        comp_t               b_w;
        logic [WEIGHT_W-1:0] weight;
    } in_t;

    typedef struct packed {
        comp_t r_x;
        comp_t r_y;
        comp_t r_z;
        comp_t r_w;
    } out_t;

    typedef struct packed {
        logic [SQRT_W-1:0] rem;
        logic [SQRT_W-1:0] root;
        logic [SQRT_W-1:0] bitv;
    } sqrt_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic                 ovf;
        logic [DIV_W-1:0]     rem;
        logic [DIV_W-1:0]     dsh;
        logic [DIV_STEPS-1:0] quo;
    } div_t;

endpackage

// ===== rtl/qslerp_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One digit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module qslerp_sqrt_cell (
    input  logic              clk,
    input  qslerp_pkg::sqrt_t cell_in,
    output qslerp_pkg::sqrt_t cell_out
);

    logic [qslerp_pkg::SQRT_W-1:0] trial;
    qslerp_pkg::sqrt_t             cell_next;
    qslerp_pkg::sqrt_t             cell_reg;

    always_comb
    begin
        trial          = cell_in.root + cell_in.bitv;
        cell_next.bitv = cell_in.bitv >> 2;
        if (cell_in.rem >= trial)
        begin
            cell_next.rem  = cell_in.rem - trial;
            cell_next.root = (cell_in.root >> 1) + cell_in.bitv;
        end
        else
        begin
            cell_next.rem  = cell_in.rem;
            cell_next.root = cell_in.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

// ===== rtl/qslerp_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation, vectoring or rotation mode, registered.
// ----------------------------------------------------------------------------
module qslerp_cordic_cell (
    input  logic                clk,
    input  logic [4:0]          idx,
    input  logic                vectoring,
    input  qslerp_pkg::cordic_t cell_in,
    output qslerp_pkg::cordic_t cell_out
);

    logic signed [qslerp_pkg::CRD_W-1:0] dx;
    logic signed [qslerp_pkg::CRD_W-1:0] dy;
    logic signed [qslerp_pkg::CRD_W-1:0] ang;
    logic                                up;
    qslerp_pkg::cordic_t                 cell_next;
    qslerp_pkg::cordic_t                 cell_reg;

    always_comb
    begin
        dx  = $signed(cell_in.y) >>> idx;
        dy  = $signed(cell_in.x) >>> idx;
        ang = $signed({4'b0000, qslerp_pkg::ATAN_Q30[idx]});
        // vectoring drives y to zero, rotation drives z to zero
        up  = vectoring ? ($signed(cell_in.y) > 0) : cell_in.z[qslerp_pkg::CRD_W-1];
        if (up)
        begin
            cell_next.x = cell_in.x + dx;
            cell_next.y = cell_in.y - dy;
            cell_next.z = cell_in.z + ang;
        end
        else
        begin
            cell_next.x = cell_in.x - dx;
            cell_next.y = cell_in.y + dy;
            cell_next.z = cell_in.z - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

// ===== rtl/qslerp_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit of a restoring division, registered.
// ----------------------------------------------------------------------------
module qslerp_div_cell (
    input  logic             clk,
    input  qslerp_pkg::div_t cell_in,
    output qslerp_pkg::div_t cell_out
);

    qslerp_pkg::div_t cell_next;
    qslerp_pkg::div_t cell_reg;

    always_comb
    begin
        cell_next.ovf = cell_in.ovf;
        cell_next.dsh = cell_in.dsh >> 1;
        if (cell_in.rem >= cell_in.dsh)
        begin
            cell_next.rem = cell_in.rem - cell_in.dsh;
            cell_next.quo = {cell_in.quo[qslerp_pkg::DIV_STEPS-2:0], 1'b1};
        end
        else
        begin
            cell_next.rem = cell_in.rem;
            cell_next.quo = {cell_in.quo[qslerp_pkg::DIV_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

// ===== rtl/quaternion_slerp.sv =====
// ----------------------------------------------------------------------------
// Quaternion slerp
// Fixed-point spherical interpolation of two Q2.14 quaternions, fully pipelined.
// ----------------------------------------------------------------------------
// Channel     Direction  Handshake            Payload
// operand     in         start, busy          qslerp_pkg::in_t
// result      out        done (strobe)        qslerp_pkg::out_t
// threshold   in         cfg_we               cfg_wdata (Q1.28)
//
// One item accepted per cycle; busy is never raised.
// Stages: dot product and square (6), square root row (29 cells),
// atan2 CORDIC row (16), angle scaling (1), sine CORDIC rows (16),
// divider rows (1 + 32 cells), weights, products and rounding (3).
// Reset clears the valid line and loads the threshold reset value.
// Results leave on done for one cycle; there is no output stall.
// ----------------------------------------------------------------------------
module quaternion_slerp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  qslerp_pkg::in_t              operand,
    output logic                         done,
    output qslerp_pkg::out_t             result,
    input  logic                         cfg_we,
    input  logic [qslerp_pkg::THR_W-1:0] cfg_wdata
);

    `include "quaternion_slerp_macros.svh"

    localparam int P_NEG  = 3;
    localparam int P_SQ0  = 5;
    localparam int P_SQE  = P_SQ0 + qslerp_pkg::SQRT_STEPS;
    localparam int P_VECE = P_SQE + qslerp_pkg::CORDIC_STEPS;
    localparam int P_ANG  = P_VECE + 1;
    localparam int P_SINE = P_ANG + qslerp_pkg::CORDIC_STEPS;
    localparam int P_DIV0 = P_SINE + 1;
    localparam int P_DIVE = P_DIV0 + qslerp_pkg::DIV_STEPS;
    localparam int P_WGT  = P_DIVE + 1;
    localparam int P_MUL  = P_WGT + 1;
    localparam int P_OUT  = P_MUL + 1;

    localparam logic [56:0] ONE_SQ   = 57'h100_0000_0000_0000;
    localparam logic [28:0] Q28_ONE  = 29'h1000_0000;
    localparam logic [31:0] K_MAX    = 32'h8000_0000;
    localparam logic [51:0] ROUND_30 = 52'h2000_0000;

    typedef struct packed {
        qslerp_pkg::comp_t [3:0]          a;
        logic [3:0][qslerp_pkg::COMP_W:0] b;
        logic [qslerp_pkg::WEIGHT_W-1:0]  t;
        logic                             byp;
        logic                             lin;
        logic [28:0]                      dc;
        logic [28:0]                      s;
    } side_t;

    logic                              accept;
    logic [qslerp_pkg::THR_W-1:0]      thr_reg;
    logic                              vld_reg [0:P_OUT];
    side_t                             side_reg  [0:P_WGT];
    side_t                             side_next [0:P_WGT];
    logic [qslerp_pkg::WEIGHT_W-1:0]   t_clamp;
    logic signed [32:0]                prod_reg [4];
    logic signed [34:0]                dsum_reg;
    logic [34:0]                       dabs;
    logic [29:0]                       hh_reg;
    logic [28:0]                       hl_reg;
    logic [27:0]                       ll_reg;
    qslerp_pkg::sqrt_t                 sq_head_reg;
    qslerp_pkg::sqrt_t                 sq_chain  [0:qslerp_pkg::SQRT_STEPS];
    qslerp_pkg::cordic_t               vec_chain [0:qslerp_pkg::CORDIC_STEPS];
    logic [30:0]                       theta;
    logic [46:0]                       m0_reg;
    logic [46:0]                       m1_reg;
    qslerp_pkg::cordic_t               sin0_chain [0:qslerp_pkg::CORDIC_STEPS];
    qslerp_pkg::cordic_t               sin1_chain [0:qslerp_pkg::CORDIC_STEPS];
    logic [30:0]                       sn0;
    logic [30:0]                       sn1;
    qslerp_pkg::div_t                  div0_head_reg;
    qslerp_pkg::div_t                  div1_head_reg;
    qslerp_pkg::div_t                  div0_chain [0:qslerp_pkg::DIV_STEPS];
    qslerp_pkg::div_t                  div1_chain [0:qslerp_pkg::DIV_STEPS];
    logic [31:0]                       k0_next;
    logic [31:0]                       k1_next;
    logic [31:0]                       k0_reg;
    logic [31:0]                       k1_reg;
    logic signed [49:0]                mul_a_reg [4];
    logic signed [49:0]                mul_b_reg [4];
    logic signed [qslerp_pkg::COMP_W-1:0] res_next [4];
    qslerp_pkg::out_t                  result_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= qslerp_pkg::THR_RESET;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n <= P_OUT; n++)
                vld_reg[n] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int n = 1; n <= P_OUT; n++)
                vld_reg[n] <= vld_reg[n-1];
        end
    end

    // side band: operands, weight and path flags travel alongside the cells
    always_comb
    begin
        t_clamp = (operand.weight > qslerp_pkg::WEIGHT_ONE) ? qslerp_pkg::WEIGHT_ONE
                                                           : operand.weight;
        side_next[0].a   = {operand.a_w, operand.a_z, operand.a_y, operand.a_x};
        side_next[0].b   = {{operand.b_w[15], operand.b_w}, {operand.b_z[15], operand.b_z},
                            {operand.b_y[15], operand.b_y}, {operand.b_x[15], operand.b_x}};
        side_next[0].t   = t_clamp;
        side_next[0].byp = (t_clamp == qslerp_pkg::WEIGHT_ONE) || (t_clamp == '0);
        side_next[0].lin = side_next[0].byp;
        side_next[0].dc  = '0;
        side_next[0].s   = '0;
        for (int n = 1; n <= P_WGT; n++)
            side_next[n] = side_reg[n-1];

        // fold the sign of the dot product into b (not on the bypass path)
        dabs = dsum_reg[34] ? 35'(-dsum_reg) : 35'(dsum_reg);
        if (dsum_reg[34] && !side_reg[P_NEG-1].byp)
        begin
            for (int i = 0; i < 4; i++)
                side_next[P_NEG].b[i] = -side_reg[P_NEG-1].b[i];
        end
        side_next[P_NEG].lin = side_reg[P_NEG-1].byp || (dabs > 35'(thr_reg));
        side_next[P_NEG].dc  = (dabs > 35'(Q28_ONE)) ? Q28_ONE : dabs[28:0];

        side_next[P_SQE+1].s   = sq_chain[qslerp_pkg::SQRT_STEPS].root[28:0];
        side_next[P_SQE+1].lin = side_reg[P_SQE].lin ||
                                 (sq_chain[qslerp_pkg::SQRT_STEPS].root[28:0] == '0);
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n <= P_WGT; n++)
            side_reg[n] <= side_next[n];
    end

    // dot product, d squared split into narrow partial products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            prod_reg[i] <= $signed(side_reg[0].a[i]) * $signed(side_reg[0].b[i]);
        dsum_reg <= 35'(prod_reg[0]) + 35'(prod_reg[1]) + 35'(prod_reg[2]) + 35'(prod_reg[3]);
        hh_reg   <= side_reg[P_NEG].dc[28:14] * side_reg[P_NEG].dc[28:14];
        hl_reg   <= side_reg[P_NEG].dc[28:14] * side_reg[P_NEG].dc[13:0];
        ll_reg   <= side_reg[P_NEG].dc[13:0] * side_reg[P_NEG].dc[13:0];
        sq_head_reg.rem  <= {1'b0, ONE_SQ - ((57'(hh_reg) << 28) + (57'(hl_reg) << 15)
                                             + 57'(ll_reg))};
        sq_head_reg.root <= '0;
        sq_head_reg.bitv <= {1'b0, ONE_SQ};
    end

    assign sq_chain[0] = sq_head_reg;

    genvar j;
    generate
        for (j = 0; j < qslerp_pkg::SQRT_STEPS; j++)
        begin : g_sqrt
            qslerp_sqrt_cell u_cell (
                .clk      (clk),
                .cell_in  (sq_chain[j]),
                .cell_out (sq_chain[j+1])
            );
        end
    endgenerate

    // theta = atan2(s, dc)
    assign vec_chain[0].x = 36'(side_reg[P_SQE].dc);
    assign vec_chain[0].y = 36'(sq_chain[qslerp_pkg::SQRT_STEPS].root[28:0]);
    assign vec_chain[0].z = '0;

    generate
        for (j = 0; j < qslerp_pkg::CORDIC_STEPS; j++)
        begin : g_vec
            qslerp_cordic_cell u_cell (
                .clk       (clk),
                .idx       (5'(j)),
                .vectoring (1'b1),
                .cell_in   (vec_chain[j]),
                .cell_out  (vec_chain[j+1])
            );
        end
    endgenerate

    assign theta = vec_chain[qslerp_pkg::CORDIC_STEPS].z[qslerp_pkg::CRD_W-1] ? '0
                 : vec_chain[qslerp_pkg::CORDIC_STEPS].z[30:0];

    always_ff @(posedge clk)
    begin
        m0_reg <= 47'(theta) * 47'(qslerp_pkg::WEIGHT_ONE - side_reg[P_VECE].t);
        m1_reg <= 47'(theta) * 47'(side_reg[P_VECE].t);
    end

    assign sin0_chain[0].x = qslerp_pkg::CORDIC_KINV;
    assign sin0_chain[0].y = '0;
    assign sin0_chain[0].z = 36'(m0_reg[46:15]);
    assign sin1_chain[0].x = qslerp_pkg::CORDIC_KINV;
    assign sin1_chain[0].y = '0;
    assign sin1_chain[0].z = 36'(m1_reg[46:15]);

    generate
        for (j = 0; j < qslerp_pkg::CORDIC_STEPS; j++)
        begin : g_sin
            qslerp_cordic_cell u_cell0 (
                .clk       (clk),
                .idx       (5'(j)),
                .vectoring (1'b0),
                .cell_in   (sin0_chain[j]),
                .cell_out  (sin0_chain[j+1])
            );
            qslerp_cordic_cell u_cell1 (
                .clk       (clk),
                .idx       (5'(j)),
                .vectoring (1'b0),
                .cell_in   (sin1_chain[j]),
                .cell_out  (sin1_chain[j+1])
            );
        end
    endgenerate

    // sines clamped to [0, 1]; quotient beyond 32 bits flagged up front
    always_comb
    begin
        if (sin0_chain[qslerp_pkg::CORDIC_STEPS].y[qslerp_pkg::CRD_W-1])
            sn0 = '0;
        else if (sin0_chain[qslerp_pkg::CORDIC_STEPS].y > 36'sd1073741824)
            sn0 = 31'h4000_0000;
        else
            sn0 = sin0_chain[qslerp_pkg::CORDIC_STEPS].y[30:0];
        if (sin1_chain[qslerp_pkg::CORDIC_STEPS].y[qslerp_pkg::CRD_W-1])
            sn1 = '0;
        else if (sin1_chain[qslerp_pkg::CORDIC_STEPS].y > 36'sd1073741824)
            sn1 = 31'h4000_0000;
        else
            sn1 = sin1_chain[qslerp_pkg::CORDIC_STEPS].y[30:0];
    end

    always_ff @(posedge clk)
    begin
        div0_head_reg.ovf <= {2'b00, sn0, 28'b0} >= {side_reg[P_SINE].s, 32'b0};
        div0_head_reg.rem <= {2'b00, sn0, 28'b0};
        div0_head_reg.dsh <= {1'b0, side_reg[P_SINE].s, 31'b0};
        div0_head_reg.quo <= '0;
        div1_head_reg.ovf <= {2'b00, sn1, 28'b0} >= {side_reg[P_SINE].s, 32'b0};
        div1_head_reg.rem <= {2'b00, sn1, 28'b0};
        div1_head_reg.dsh <= {1'b0, side_reg[P_SINE].s, 31'b0};
        div1_head_reg.quo <= '0;
    end

    assign div0_chain[0] = div0_head_reg;
    assign div1_chain[0] = div1_head_reg;

    generate
        for (j = 0; j < qslerp_pkg::DIV_STEPS; j++)
        begin : g_div
            qslerp_div_cell u_cell0 (
                .clk      (clk),
                .cell_in  (div0_chain[j]),
                .cell_out (div0_chain[j+1])
            );
            qslerp_div_cell u_cell1 (
                .clk      (clk),
                .cell_in  (div1_chain[j]),
                .cell_out (div1_chain[j+1])
            );
        end
    endgenerate

    always_comb
    begin
        if (side_reg[P_DIVE].lin)
        begin
            k0_next = {1'b0, qslerp_pkg::WEIGHT_ONE - side_reg[P_DIVE].t, 15'b0};
            k1_next = {1'b0, side_reg[P_DIVE].t, 15'b0};
        end
        else
        begin
            k0_next = (div0_chain[qslerp_pkg::DIV_STEPS].ovf ||
                       div0_chain[qslerp_pkg::DIV_STEPS].quo > K_MAX) ? K_MAX
                    : div0_chain[qslerp_pkg::DIV_STEPS].quo;
            k1_next = (div1_chain[qslerp_pkg::DIV_STEPS].ovf ||
                       div1_chain[qslerp_pkg::DIV_STEPS].quo > K_MAX) ? K_MAX
                    : div1_chain[qslerp_pkg::DIV_STEPS].quo;
        end
    end

    always_ff @(posedge clk)
    begin
        k0_reg <= k0_next;
        k1_reg <= k1_next;
        for (int i = 0; i < 4; i++)
        begin
            mul_a_reg[i] <= $signed({1'b0, k0_reg}) * $signed(side_reg[P_WGT].a[i]);
            mul_b_reg[i] <= $signed({1'b0, k1_reg}) * $signed(side_reg[P_WGT].b[i]);
        end
    end

    // round to Q2.14 and saturate
    always_comb
    begin
        logic signed [51:0] acc;
        logic signed [21:0] sh;
        for (int i = 0; i < 4; i++)
        begin
            acc = 52'(mul_a_reg[i]) + 52'(mul_b_reg[i]) + $signed(ROUND_30);
            sh  = acc[51:30];
            if (sh > 22'sd32767)
                res_next[i] = 16'sh7FFF;
            else if (sh < -22'sd32768)
                res_next[i] = 16'sh8000;
            else
                res_next[i] = sh[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.r_x <= res_next[0];
        result_reg.r_y <= res_next[1];
        result_reg.r_z <= res_next[2];
        result_reg.r_w <= res_next[3];
    end

    assign result = result_reg;
    assign done   = vld_reg[P_OUT];

    `QS_ASSERT_NEXT(chk_bypass, accept && (operand.weight == '0), side_reg[0].byp && side_reg[0].lin)
    `QS_ASSERT_ALWAYS(chk_root_range, !vld_reg[P_SQE+1] || (side_reg[P_SQE+1].s <= Q28_ONE))
    `QS_ASSERT_ALWAYS(chk_lin_weights, !(vld_reg[P_WGT] && side_reg[P_WGT].lin) || ((33'(k0_reg) + 33'(k1_reg)) == 33'h4000_0000))
    `QS_ASSERT_ALWAYS(chk_weight_cap, !vld_reg[P_WGT] || ((k0_reg <= K_MAX) && (k1_reg <= K_MAX)))

endmodule
